/* hw/rtl/pfrd_pkg.sv */
// Shared constants, command codes, control structs and mask helper for the rectangle drawer.
package pfrd_pkg;

    // Frame geometry
    localparam int WIDTH_PIXELS  = 128;
    localparam int HEIGHT_PIXELS = 64;
    localparam int PAGE_COUNT    = (HEIGHT_PIXELS + 7) / 8;
    localparam int STORE_BYTES   = WIDTH_PIXELS * PAGE_COUNT;

    localparam int COL_W  = $clog2(WIDTH_PIXELS);
    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int ROW_W  = PAGE_W + 3;
    localparam int ADDR_W = $clog2(STORE_BYTES);

    // Port field widths
    localparam int CMD_W  = 3;
    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int RW_W   = 8;
    localparam int RH_W   = 7;
    localparam int RA_W   = 10;
    localparam int DATA_W = 8;

    // Widths for edge checks, wide enough for origin plus size
    localparam int SUMX_W = 10;
    localparam int SUMY_W = 9;
    localparam int SUMA_W = RA_W + 1;

    localparam logic [DATA_W-1:0] BIT0_MASK = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PIXEL = 3'd0,
        CMD_RECT_LINE = 3'd1,
        CMD_RECT_FILL = 3'd2,
        CMD_CLEAR     = 3'd3,
        CMD_READ      = 3'd4
    } t_cmd_code;

    // Strobes from controller to datapath
    typedef struct packed {
        logic load;
        logic pix_step;
        logic draw_step;
        logic rd_step;
        logic clr_step;
        logic out_load;
        logic out_err;
        logic out_data;
    } t_dp_cmd;

    // Flags from datapath to controller
    typedef struct packed {
        logic pix_bad;
        logic rect_bad;
        logic rd_bad;
        logic draw_last;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    // Bits of rows lo..hi that fall in page pg
    function automatic logic [DATA_W-1:0] span_mask(
        input logic [PAGE_W-1:0] pg,
        input logic [ROW_W-1:0]  lo,
        input logic [ROW_W-1:0]  hi
    );
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < DATA_W; b++) begin
            row  = {pg, 3'(b)};
            m[b] = (row >= lo) && (row <= hi);
        end
        return m;
    endfunction

endpackage

/* hw/rtl/pfrd_datapath.sv */
// Datapath: frame store, read-modify-write pipe, address walkers, range checks, result word.
module pfrd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pfrd_pkg::CMD_W-1:0]    i_command,
    input  logic [pfrd_pkg::X_W-1:0]      i_pos_x,
    input  logic [pfrd_pkg::Y_W-1:0]      i_pos_y,
    input  logic [pfrd_pkg::RW_W-1:0]     i_rect_width,
    input  logic [pfrd_pkg::RH_W-1:0]     i_rect_height,
    input  logic                          i_pixel_value,
    input  logic [pfrd_pkg::RA_W-1:0]     i_read_address,
    input  pfrd_pkg::t_dp_cmd             i_cmd,
    output pfrd_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [pfrd_pkg::DATA_W-1:0]   o_read_data
);
    import pfrd_pkg::*;

    logic [DATA_W-1:0] r_mem [STORE_BYTES];

    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;
    logic [RW_W-1:0]   r_w;
    logic [RH_W-1:0]   r_h;
    logic              r_val;
    logic              r_fill;
    logic [RA_W-1:0]   r_raddr;

    logic [COL_W-1:0]  r_col;
    logic [PAGE_W-1:0] r_pg;
    logic [ADDR_W-1:0] r_clr;

    logic [DATA_W-1:0] r_rdata;
    logic              r_wen;
    logic              r_wclr;
    logic [ADDR_W-1:0] r_waddr;
    logic [DATA_W-1:0] r_wmask;

    logic              r_out_valid;
    logic              r_status;
    logic [DATA_W-1:0] r_odata;

    logic [SUMX_W-1:0] sum_x;
    logic [SUMY_W-1:0] sum_y;
    logic              x_out;
    logic              y_out;
    logic [COL_W-1:0]  right;
    logic [ROW_W-1:0]  top;
    logic [ROW_W-1:0]  bottom;
    logic [PAGE_W-1:0] pg_last;
    logic [DATA_W-1:0] side_mask;
    logic [DATA_W-1:0] inner_mask;
    logic [DATA_W-1:0] draw_mask;
    logic [DATA_W-1:0] pix_mask;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] pix_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] wdata;
    logic              col_is_side;

    // Rectangle extent and range checks
    assign sum_x   = SUMX_W'(r_x) + SUMX_W'(r_w);
    assign sum_y   = SUMY_W'(r_y) + SUMY_W'(r_h);
    assign x_out   = SUMX_W'(r_x) >= SUMX_W'(WIDTH_PIXELS);
    assign y_out   = SUMY_W'(r_y) >= SUMY_W'(HEIGHT_PIXELS);
    assign right   = COL_W'(sum_x - SUMX_W'(1));
    assign top     = ROW_W'(r_y);
    assign bottom  = ROW_W'(sum_y - SUMY_W'(1));
    assign pg_last = bottom[ROW_W-1:3];

    // Page masks: whole span for side columns or a fill, else the top and bottom rows
    assign side_mask   = span_mask(r_pg, top, bottom);
    assign inner_mask  = r_fill ? side_mask
                                : (span_mask(r_pg, top, top) | span_mask(r_pg, bottom, bottom));
    assign col_is_side = (r_col == COL_W'(r_x)) || (r_col == right);
    assign draw_mask   = col_is_side ? side_mask : inner_mask;
    assign draw_addr   = ADDR_W'(r_pg) * ADDR_W'(WIDTH_PIXELS) + ADDR_W'(r_col);

    // Single pixel
    assign pix_mask = BIT0_MASK << r_y[2:0];
    assign pix_addr = ADDR_W'(r_y[Y_W-1:3]) * ADDR_W'(WIDTH_PIXELS) + ADDR_W'(r_x);

    // Read port select
    always_comb begin
        rd_en = i_cmd.pix_step || i_cmd.draw_step || i_cmd.rd_step;
        if (i_cmd.pix_step) begin
            rd_addr = pix_addr;
        end else if (i_cmd.draw_step) begin
            rd_addr = draw_addr;
        end else begin
            rd_addr = ADDR_W'(r_raddr);
        end
    end

    assign wdata = r_wclr ? (r_rdata & ~r_wmask) : (r_rdata | r_wmask);

    // Status back to the controller
    always_comb begin
        o_stat.pix_bad   = x_out || y_out;
        o_stat.rect_bad  = x_out || y_out || (r_w == '0) || (r_h == '0)
                           || (sum_x > SUMX_W'(WIDTH_PIXELS))
                           || (sum_y > SUMY_W'(HEIGHT_PIXELS));
        o_stat.rd_bad    = SUMA_W'(r_raddr) >= SUMA_W'(STORE_BYTES);
        o_stat.draw_last = (r_col == right) && (r_pg == pg_last);
        o_stat.clr_last  = r_clr == ADDR_W'(STORE_BYTES - 1);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    // Capture of the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_val   <= i_pixel_value;
            r_raddr <= i_read_address;
            r_fill  <= i_command == CMD_RECT_FILL;
        end
    end

    // Column and page walker, then clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_pg  <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.load) begin
                r_col <= COL_W'(i_pos_x);
                r_pg  <= PAGE_W'(i_pos_y >> 3);
            end else if (i_cmd.draw_step) begin
                if (r_col == right) begin
                    r_col <= COL_W'(r_x);
                    r_pg  <= r_pg + PAGE_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (i_cmd.clr_step) begin
                r_clr <= o_stat.clr_last ? '0 : r_clr + ADDR_W'(1);
            end
        end
    end

    // Write stage of the read-modify-write pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wen <= 1'b0;
        end else begin
            r_wen <= i_cmd.pix_step || i_cmd.draw_step;
        end
        r_waddr <= rd_addr;
        r_wmask <= i_cmd.pix_step ? pix_mask : draw_mask;
        r_wclr  <= i_cmd.pix_step && !r_val;
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.clr_step) begin
            r_mem[r_clr] <= '0;
        end else if (r_wen) begin
            r_mem[r_waddr] <= wdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_err;
            r_odata  <= i_cmd.out_data ? r_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_odata;

endmodule

/* hw/rtl/pfrd_ctrl.sv */
// Controller: sequences the clear sweep, rectangle walk, pixel update and read.
module pfrd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pfrd_pkg::CMD_W-1:0]  i_command,
    output pfrd_pkg::t_dp_cmd           o_cmd,
    input  pfrd_pkg::t_dp_stat          i_stat
);
    import pfrd_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_DRAW,
        S_CLEAR,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state    r_state, n_state;
    t_cmd_code r_op, n_op;
    logic      r_err, n_err;
    logic      r_dsel, n_dsel;

    // Next state and datapath strobes
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_err   = r_err;
        n_dsel  = r_dsel;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = t_cmd_code'(i_command);
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_err  = 1'b0;
                n_dsel = 1'b0;
                unique case (r_op) inside
                    CMD_SET_PIXEL: begin
                        if (i_stat.pix_bad) begin
                            n_err   = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.pix_step = 1'b1;
                            n_state        = S_DRAIN;
                        end
                    end
                    CMD_RECT_LINE, CMD_RECT_FILL: begin
                        if (i_stat.rect_bad) begin
                            n_err   = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_DRAW;
                        end
                    end
                    CMD_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    CMD_READ: begin
                        if (i_stat.rd_bad) begin
                            n_err = 1'b1;
                        end else begin
                            o_cmd.rd_step = 1'b1;
                            n_dsel        = 1'b1;
                        end
                        n_state = S_FINISH;
                    end
                    default: begin
                        n_err   = 1'b1;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_DRAW: begin
                o_cmd.draw_step = 1'b1;
                if (i_stat.draw_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_FINISH;
                end
            end
            S_DRAIN: begin
                // last byte written back this cycle
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = r_err;
                    o_cmd.out_data = r_dsel;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

    // State and held flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_op    <= CMD_SET_PIXEL;
            r_err   <= 1'b0;
            r_dsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_err   <= n_err;
            r_dsel  <= n_dsel;
        end
    end

endmodule

/* hw/rtl/page_framebuffer_rect_draw.sv */
// Top level of the page framebuffer drawing engine.
//
//  channel   direction  handshake                  payload
//  command   in         i_in_valid / o_in_stall    i_command, i_pos_x, i_pos_y, i_rect_width,
//                                                  i_rect_height, i_pixel_value, i_read_address
//  result    out        o_out_valid / i_out_stall  o_status, o_read_data
//
// A read or a rejected command goes from decode straight to the finish state; a pixel update and
// a rectangle walk pass through a drain state first, and a clear sweeps the whole store. The walk
// does one read-modify-write per cycle on the frame store, reading one byte while writing back
// the one before it. After reset a clearing pass runs with the command channel stalled. The
// result register frees the engine to accept the next word while a result is stalled; a word that
// finishes before the result is taken waits for it.
module page_framebuffer_rect_draw (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pfrd_pkg::CMD_W-1:0]    i_command,
    input  logic [pfrd_pkg::X_W-1:0]      i_pos_x,
    input  logic [pfrd_pkg::Y_W-1:0]      i_pos_y,
    input  logic [pfrd_pkg::RW_W-1:0]     i_rect_width,
    input  logic [pfrd_pkg::RH_W-1:0]     i_rect_height,
    input  logic                          i_pixel_value,
    input  logic [pfrd_pkg::RA_W-1:0]     i_read_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [pfrd_pkg::DATA_W-1:0]   o_read_data
);
    import pfrd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    pfrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // Store and arithmetic
    pfrd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_pixel_value  (i_pixel_value),
        .i_read_address (i_read_address),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_read_data    (o_read_data)
    );

endmodule
